>>> rtl/free_list_heap_allocator_top_assert.svh
// Assertion macros shared by the allocator modules.
`ifndef FREE_LIST_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_LIST_HEAP_ALLOCATOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FLHA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FLHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/flha_pkg.sv
// Package with types, constants and command encodings of the heap allocator.
`default_nettype none
package flha_pkg;
    localparam int unsigned HEAP_BYTES = 1048576;
    localparam int unsigned HEADER_BYTES = 24;
    localparam int unsigned FREE_ENTRIES = 64;
    localparam int unsigned USED_ENTRIES = 64;
    localparam int unsigned AW = 21;
    localparam int unsigned FIW = $clog2(FREE_ENTRIES);
    localparam int unsigned UIW = $clog2(USED_ENTRIES);
    localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);
    localparam int unsigned UCW = $clog2(USED_ENTRIES + 1);
    localparam int unsigned WW = AW + 2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE = 1'b1;

    typedef struct packed {
        logic func;
        logic [AW-1:0] request_bytes;
        logic [AW-1:0] payload_addr;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [AW-1:0] result_addr;
        logic [AW-1:0] segment_bytes;
        logic [AW-1:0] free_bytes;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_ASCAN_RD, S_ASCAN_CHK, S_ADECIDE, S_APICK_RD, S_APICK,
        S_REM_RD, S_REM_WR, S_USCAN_RD, S_USCAN_CHK, S_FSCAN_RD, S_FSCAN_CHK,
        S_PREV_RD, S_PREV_CHK, S_MERGE, S_INS_RD, S_INS_WR, S_ULAST_RD, S_ULAST_WR,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        C_NONE, C_START, C_ARD_SCAN, C_ACHK, C_ARD_PICK, C_APICK, C_ABREAK,
        C_RRD, C_RWR, C_URD_SCAN, C_UCHK, C_FRD_SCAN, C_FCHK, C_PRD, C_PCHK,
        C_MERGE, C_IRD, C_IWR, C_ULRD, C_ULWR, C_FINISH
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic null_addr;
        logic used_full;
        logic scan_end;
        logic hit;
        logic stop;
        logic found;
        logic exhausted;
        logic split;
        logic rem_done;
        logic ins_done;
        logic next_adj;
        logic prev_adj;
        logic has_prev;
        logic free_full;
        logic status_set;
        logic ulast_move;
    } status_flags_t;
endpackage
`default_nettype wire

>>> rtl/flha_datapath.sv
// Datapath of the heap allocator: free and used tables, counters and scan logic.
`default_nettype none
`include "free_list_heap_allocator_top_assert.svh"
module flha_datapath (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fit_mode,
    input  wire flha_pkg::in_item_t item,
    input  wire flha_pkg::cmd_t cmd,
    output flha_pkg::status_flags_t flags,
    output flha_pkg::out_item_t result
);
    localparam int unsigned AW = flha_pkg::AW;
    localparam int unsigned WW = flha_pkg::WW;
    localparam int unsigned FIW = flha_pkg::FIW;
    localparam int unsigned UIW = flha_pkg::UIW;
    localparam int unsigned FCW = flha_pkg::FCW;
    localparam int unsigned UCW = flha_pkg::UCW;
    localparam logic [WW-1:0] HDR = WW'(flha_pkg::HEADER_BYTES);
    localparam logic [WW-1:0] HEAP = WW'(flha_pkg::HEAP_BYTES);

    logic [AW-1:0] fs_mem [flha_pkg::FREE_ENTRIES];
    logic [AW-1:0] fl_mem [flha_pkg::FREE_ENTRIES];
    logic [AW-1:0] us_mem [flha_pkg::USED_ENTRIES];
    logic [AW-1:0] ul_mem [flha_pkg::USED_ENTRIES];

    logic [AW-1:0] fs_rd_reg, fl_rd_reg, us_rd_reg, ul_rd_reg;
    logic [FCW-1:0] free_count_reg, free_count_next;
    logic [UCW-1:0] used_count_reg, used_count_next;
    logic [AW-1:0] heap_break_reg, heap_break_next;
    logic [AW-1:0] free_total_reg, free_total_next;
    logic [FCW-1:0] fidx_reg, fidx_next;
    logic [UCW-1:0] uidx_reg, uidx_next;
    logic [FCW-1:0] pick_reg, pick_next;
    logic found_reg, found_next;
    logic [AW-1:0] best_reg, best_next;
    logic stop_reg, stop_next;
    logic hit_reg, hit_next;
    logic [AW-1:0] s_reg, s_next;
    logic [AW-1:0] l_reg, l_next;
    logic [AW-1:0] nlen_reg, nlen_next;
    logic next_reg, next_next;
    logic [1:0] status_reg, status_next;
    logic status_set_reg, status_set_next;
    logic [AW-1:0] res_reg, res_next;

    logic [WW-1:0] need;
    logic [FIW-1:0] f_raddr, f_waddr;
    logic f_we;
    logic [AW-1:0] f_wstart, f_wlen;
    logic [UIW-1:0] u_raddr, u_waddr;
    logic u_we;
    logic [AW-1:0] u_wstart, u_wlen;
    logic [WW-1:0] fend, uend;
    logic fits;

    assign need = WW'(item.request_bytes) + HDR;
    assign fend = WW'(fs_rd_reg) + WW'(fl_rd_reg);
    assign uend = WW'(us_rd_reg) + WW'(ul_rd_reg);
    assign fits = WW'(fl_rd_reg) >= need;

    always_ff @(posedge aclk) begin
        if (f_we) begin
            fs_mem[f_waddr] <= f_wstart;
            fl_mem[f_waddr] <= f_wlen;
        end
        fs_rd_reg <= fs_mem[f_raddr];
        fl_rd_reg <= fl_mem[f_raddr];
        if (u_we) begin
            us_mem[u_waddr] <= u_wstart;
            ul_mem[u_waddr] <= u_wlen;
        end
        us_rd_reg <= us_mem[u_raddr];
        ul_rd_reg <= ul_mem[u_raddr];
    end

    always_comb begin
        free_count_next = free_count_reg;
        used_count_next = used_count_reg;
        heap_break_next = heap_break_reg;
        free_total_next = free_total_reg;
        fidx_next = fidx_reg;
        uidx_next = uidx_reg;
        pick_next = pick_reg;
        found_next = found_reg;
        best_next = best_reg;
        stop_next = stop_reg;
        hit_next = hit_reg;
        s_next = s_reg;
        l_next = l_reg;
        nlen_next = nlen_reg;
        next_next = next_reg;
        status_next = status_reg;
        status_set_next = status_set_reg;
        res_next = res_reg;
        f_raddr = fidx_reg[FIW-1:0];
        f_we = 1'b0;
        f_waddr = fidx_reg[FIW-1:0];
        f_wstart = fs_rd_reg;
        f_wlen = fl_rd_reg;
        u_raddr = uidx_reg[UIW-1:0];
        u_we = 1'b0;
        u_waddr = uidx_reg[UIW-1:0];
        u_wstart = s_reg;
        u_wlen = l_reg;
        case (cmd)
            flha_pkg::C_START: begin
                fidx_next = '0;
                uidx_next = '0;
                found_next = 1'b0;
                stop_next = 1'b0;
                hit_next = 1'b0;
                status_next = flha_pkg::ST_OK;
                status_set_next = 1'b0;
                res_next = '0;
            end
            flha_pkg::C_ARD_SCAN, flha_pkg::C_FRD_SCAN: begin
                f_raddr = fidx_reg[FIW-1:0];
            end
            flha_pkg::C_ACHK: begin
                if (fits) begin
                    if (!found_reg || fl_rd_reg < best_reg) begin
                        pick_next = fidx_reg;
                        best_next = fl_rd_reg;
                        found_next = 1'b1;
                    end
                    if (!fit_mode || WW'(fl_rd_reg) == need) begin
                        stop_next = 1'b1;
                    end
                end
                fidx_next = fidx_reg + 1'b1;
            end
            flha_pkg::C_ARD_PICK: begin
                f_raddr = pick_reg[FIW-1:0];
            end
            flha_pkg::C_APICK: begin
                s_next = fs_rd_reg;
                free_total_next = AW'(WW'(free_total_reg) - (flags.split ? need
                                      : WW'(fl_rd_reg)));
                if (flags.split) begin
                    l_next = AW'(need);
                    f_we = 1'b1;
                    f_waddr = pick_reg[FIW-1:0];
                    f_wstart = AW'(WW'(fs_rd_reg) + need);
                    f_wlen = AW'(WW'(fl_rd_reg) - need);
                end else begin
                    l_next = fl_rd_reg;
                    fidx_next = pick_reg;
                end
                res_next = AW'(WW'(fs_rd_reg) + HDR);
                u_we = 1'b1;
                u_waddr = used_count_reg[UIW-1:0];
                u_wstart = fs_rd_reg;
                u_wlen = flags.split ? AW'(need) : fl_rd_reg;
                used_count_next = used_count_reg + 1'b1;
            end
            flha_pkg::C_ABREAK: begin
                if (!flags.exhausted) begin
                    u_we = 1'b1;
                    u_waddr = used_count_reg[UIW-1:0];
                    u_wstart = heap_break_reg;
                    u_wlen = AW'(need);
                    used_count_next = used_count_reg + 1'b1;
                    res_next = AW'(WW'(heap_break_reg) + HDR);
                    heap_break_next = AW'(WW'(heap_break_reg) + need);
                end else begin
                    status_next = flha_pkg::ST_EXHAUSTED;
                end
            end
            flha_pkg::C_RRD: begin
                f_raddr = FIW'(fidx_reg + 1'b1);
            end
            flha_pkg::C_RWR: begin
                f_we = 1'b1;
                f_waddr = fidx_reg[FIW-1:0];
                fidx_next = fidx_reg + 1'b1;
                if (flags.rem_done) begin
                    free_count_next = free_count_reg - 1'b1;
                end
            end
            flha_pkg::C_URD_SCAN: begin
                u_raddr = uidx_reg[UIW-1:0];
            end
            flha_pkg::C_UCHK: begin
                if (uend == WW'(0) || WW'(us_rd_reg) + HDR == WW'(item.payload_addr)) begin
                    hit_next = WW'(us_rd_reg) + HDR == WW'(item.payload_addr);
                end
                if (WW'(us_rd_reg) + HDR == WW'(item.payload_addr)) begin
                    s_next = us_rd_reg;
                    l_next = ul_rd_reg;
                end else begin
                    uidx_next = uidx_reg + 1'b1;
                end
            end
            flha_pkg::C_FCHK: begin
                if (!flags.scan_end && fs_rd_reg < s_reg) begin
                    fidx_next = fidx_reg + 1'b1;
                end else begin
                    stop_next = 1'b1;
                    next_next = !flags.scan_end && WW'(s_reg) + WW'(l_reg) == WW'(fs_rd_reg);
                    nlen_next = fl_rd_reg;
                end
            end
            flha_pkg::C_PRD: begin
                f_raddr = FIW'(fidx_reg - 1'b1);
            end
            flha_pkg::C_PCHK: begin
                f_raddr = FIW'(fidx_reg - 1'b1);
                hit_next = flags.has_prev && fend == WW'(s_reg);
            end
            flha_pkg::C_MERGE: begin
                if (hit_reg) begin
                    f_we = 1'b1;
                    f_waddr = FIW'(fidx_reg - 1'b1);
                    f_wstart = fs_rd_reg;
                    f_wlen = AW'(WW'(fl_rd_reg) + WW'(l_reg)
                                 + (next_reg ? WW'(nlen_reg) : WW'(0)));
                    free_total_next = AW'(WW'(free_total_reg) + WW'(l_reg));
                end else if (next_reg) begin
                    f_we = 1'b1;
                    f_waddr = fidx_reg[FIW-1:0];
                    f_wstart = s_reg;
                    f_wlen = AW'(WW'(nlen_reg) + WW'(l_reg));
                    free_total_next = AW'(WW'(free_total_reg) + WW'(l_reg));
                end else if (free_count_reg >= FCW'(flha_pkg::FREE_ENTRIES)) begin
                    status_next = flha_pkg::ST_FULL;
                end else begin
                    free_total_next = AW'(WW'(free_total_reg) + WW'(l_reg));
                    pick_next = fidx_reg;
                    fidx_next = free_count_reg;
                end
            end
            flha_pkg::C_IRD: begin
                f_raddr = FIW'(fidx_reg - 1'b1);
            end
            flha_pkg::C_IWR: begin
                f_we = 1'b1;
                if (flags.ins_done) begin
                    f_waddr = fidx_reg[FIW-1:0];
                    f_wstart = s_reg;
                    f_wlen = l_reg;
                    free_count_next = free_count_reg + 1'b1;
                end else begin
                    f_waddr = fidx_reg[FIW-1:0];
                    fidx_next = fidx_reg - 1'b1;
                end
            end
            flha_pkg::C_ULRD: begin
                u_raddr = UIW'(used_count_reg - 1'b1);
            end
            flha_pkg::C_ULWR: begin
                u_we = 1'b1;
                u_waddr = uidx_reg[UIW-1:0];
                u_wstart = us_rd_reg;
                u_wlen = ul_rd_reg;
                used_count_next = used_count_reg - 1'b1;
            end
            flha_pkg::C_FINISH: begin
                status_set_next = 1'b1;
            end
            default: begin
            end
        endcase
        if (cmd == flha_pkg::C_ACHK && !fits) begin
            stop_next = stop_reg;
        end
        if (cmd == flha_pkg::C_ACHK || cmd == flha_pkg::C_MERGE) begin
            if (cmd == flha_pkg::C_ACHK) begin
                u_raddr = uidx_reg[UIW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_count_reg <= '0;
            used_count_reg <= '0;
            heap_break_reg <= '0;
            free_total_reg <= '0;
            status_set_reg <= 1'b0;
        end else begin
            free_count_reg <= free_count_next;
            used_count_reg <= used_count_next;
            heap_break_reg <= heap_break_next;
            free_total_reg <= free_total_next;
            status_set_reg <= status_set_next;
        end
        fidx_reg <= fidx_next;
        uidx_reg <= uidx_next;
        pick_reg <= pick_next;
        found_reg <= found_next;
        best_reg <= best_next;
        stop_reg <= stop_next;
        hit_reg <= hit_next;
        s_reg <= s_next;
        l_reg <= l_next;
        nlen_reg <= nlen_next;
        next_reg <= next_next;
        status_reg <= status_next;
        res_reg <= res_next;
    end

    always_comb begin
        flags.is_alloc = item.func == flha_pkg::FUNC_ALLOC;
        flags.null_addr = item.payload_addr == '0;
        flags.used_full = used_count_reg >= UCW'(flha_pkg::USED_ENTRIES);
        flags.scan_end = fidx_reg >= free_count_reg;
        flags.hit = hit_reg;
        flags.stop = stop_reg || (fidx_reg >= free_count_reg);
        flags.found = found_reg;
        flags.exhausted = WW'(heap_break_reg) + need > HEAP;
        flags.split = WW'(fl_rd_reg) > WW'(item.request_bytes) + HDR + HDR;
        flags.rem_done = FCW'(fidx_reg + 1'b1) >= FCW'(free_count_reg - 1'b1);
        flags.ins_done = fidx_reg == pick_reg;
        flags.next_adj = next_reg;
        flags.prev_adj = hit_reg;
        flags.has_prev = fidx_reg != '0;
        flags.free_full = status_reg == flha_pkg::ST_FULL;
        flags.status_set = status_set_reg;
        flags.ulast_move = uidx_reg >= used_count_reg;
        result.status = status_reg;
        result.result_addr = res_reg;
        result.segment_bytes = heap_break_reg;
        result.free_bytes = free_total_reg;
    end

    `FLHA_ASSERT_IMP(a_free_count_range, aclk, aresetn, 1'b1,
        free_count_reg <= FCW'(flha_pkg::FREE_ENTRIES), "free count out of range")
    `FLHA_ASSERT_IMP(a_used_count_range, aclk, aresetn, 1'b1,
        used_count_reg <= UCW'(flha_pkg::USED_ENTRIES), "used count out of range")
    `FLHA_ASSERT_NEXT(a_break_grows, aclk, aresetn, cmd == flha_pkg::C_ABREAK,
        heap_break_reg >= $past(heap_break_reg), "heap break shrank")
endmodule
`default_nettype wire

>>> rtl/flha_controller.sv
// Controller state machine sequencing allocate and free transactions.
`default_nettype none
`include "free_list_heap_allocator_top_assert.svh"
module flha_controller (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  wire logic out_ready,
    input  wire flha_pkg::status_flags_t flags,
    output flha_pkg::cmd_t cmd,
    output logic [1:0] early_status,
    output logic early_use
);
    flha_pkg::state_t state_reg, state_next;
    logic [1:0] est_reg, est_next;
    logic euse_reg, euse_next;

    always_comb begin
        state_next = state_reg;
        est_next = est_reg;
        euse_next = euse_reg;
        case (state_reg)
            flha_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = flha_pkg::S_DISPATCH;
                    euse_next = 1'b0;
                end
            end
            flha_pkg::S_DISPATCH: begin
                if (flags.is_alloc) begin
                    if (flags.used_full) begin
                        est_next = flha_pkg::ST_FULL;
                        euse_next = 1'b1;
                        state_next = flha_pkg::S_DONE;
                    end else begin
                        state_next = flha_pkg::S_ASCAN_RD;
                    end
                end else if (flags.null_addr) begin
                    state_next = flha_pkg::S_DONE;
                end else begin
                    state_next = flha_pkg::S_USCAN_RD;
                end
            end
            flha_pkg::S_ASCAN_RD: begin
                state_next = flags.stop ? flha_pkg::S_ADECIDE : flha_pkg::S_ASCAN_CHK;
            end
            flha_pkg::S_ASCAN_CHK: state_next = flha_pkg::S_ASCAN_RD;
            flha_pkg::S_ADECIDE: begin
                state_next = flags.found ? flha_pkg::S_APICK_RD : flha_pkg::S_DONE;
            end
            flha_pkg::S_APICK_RD: state_next = flha_pkg::S_APICK;
            flha_pkg::S_APICK: begin
                state_next = flags.split ? flha_pkg::S_DONE : flha_pkg::S_REM_RD;
            end
            flha_pkg::S_REM_RD: begin
                if (!flags.scan_end) begin
                    state_next = flha_pkg::S_REM_WR;
                end else begin
                    state_next = flags.is_alloc ? flha_pkg::S_DONE : flha_pkg::S_ULAST_RD;
                end
            end
            flha_pkg::S_REM_WR: begin
                if (!flags.rem_done) begin
                    state_next = flha_pkg::S_REM_RD;
                end else begin
                    state_next = flags.is_alloc ? flha_pkg::S_DONE : flha_pkg::S_ULAST_RD;
                end
            end
            flha_pkg::S_USCAN_RD: begin
                if (flags.ulast_move) begin
                    est_next = flha_pkg::ST_UNKNOWN;
                    euse_next = 1'b1;
                    state_next = flha_pkg::S_DONE;
                end else begin
                    state_next = flha_pkg::S_USCAN_CHK;
                end
            end
            flha_pkg::S_USCAN_CHK: begin
                state_next = flags.hit ? flha_pkg::S_FSCAN_RD : flha_pkg::S_USCAN_RD;
            end
            flha_pkg::S_FSCAN_RD: state_next = flha_pkg::S_FSCAN_CHK;
            flha_pkg::S_FSCAN_CHK: begin
                state_next = flags.stop ? flha_pkg::S_PREV_RD : flha_pkg::S_FSCAN_RD;
            end
            flha_pkg::S_PREV_RD: state_next = flha_pkg::S_PREV_CHK;
            flha_pkg::S_PREV_CHK: state_next = flha_pkg::S_MERGE;
            flha_pkg::S_MERGE: begin
                if (flags.prev_adj && flags.next_adj) begin
                    state_next = flha_pkg::S_REM_RD;
                end else if (flags.prev_adj || flags.next_adj) begin
                    state_next = flha_pkg::S_ULAST_RD;
                end else begin
                    state_next = flha_pkg::S_INS_RD;
                end
            end
            flha_pkg::S_INS_RD: begin
                state_next = flags.free_full ? flha_pkg::S_DONE : flha_pkg::S_INS_WR;
            end
            flha_pkg::S_INS_WR: begin
                state_next = flags.ins_done ? flha_pkg::S_ULAST_RD : flha_pkg::S_INS_RD;
            end
            flha_pkg::S_ULAST_RD: state_next = flha_pkg::S_ULAST_WR;
            flha_pkg::S_ULAST_WR: state_next = flha_pkg::S_DONE;
            flha_pkg::S_DONE: begin
                if (flags.status_set && out_ready) begin
                    state_next = flha_pkg::S_IDLE;
                end
            end
            default: state_next = flha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = flha_pkg::C_NONE;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            flha_pkg::S_IDLE: begin
                in_ready = 1'b1;
                cmd = flha_pkg::C_START;
            end
            flha_pkg::S_ASCAN_RD: cmd = flha_pkg::C_ARD_SCAN;
            flha_pkg::S_ASCAN_CHK: cmd = flha_pkg::C_ACHK;
            flha_pkg::S_ADECIDE: cmd = flags.found ? flha_pkg::C_ARD_PICK : flha_pkg::C_ABREAK;
            flha_pkg::S_APICK_RD: cmd = flha_pkg::C_ARD_PICK;
            flha_pkg::S_APICK: cmd = flha_pkg::C_APICK;
            flha_pkg::S_REM_RD: cmd = flha_pkg::C_RRD;
            flha_pkg::S_REM_WR: cmd = flha_pkg::C_RWR;
            flha_pkg::S_USCAN_RD: cmd = flha_pkg::C_URD_SCAN;
            flha_pkg::S_USCAN_CHK: cmd = flha_pkg::C_UCHK;
            flha_pkg::S_FSCAN_RD: cmd = flha_pkg::C_FRD_SCAN;
            flha_pkg::S_FSCAN_CHK: cmd = flha_pkg::C_FCHK;
            flha_pkg::S_PREV_RD: cmd = flha_pkg::C_PRD;
            flha_pkg::S_PREV_CHK: cmd = flha_pkg::C_PCHK;
            flha_pkg::S_MERGE: cmd = flha_pkg::C_MERGE;
            flha_pkg::S_INS_RD: cmd = flha_pkg::C_IRD;
            flha_pkg::S_INS_WR: cmd = flha_pkg::C_IWR;
            flha_pkg::S_ULAST_RD: cmd = flha_pkg::C_ULRD;
            flha_pkg::S_ULAST_WR: cmd = flha_pkg::C_ULWR;
            flha_pkg::S_DONE: begin
                out_valid = flags.status_set;
                if (!flags.status_set) begin
                    cmd = flha_pkg::C_FINISH;
                end
            end
            default: cmd = flha_pkg::C_NONE;
        endcase
    end

    assign early_status = est_reg;
    assign early_use = euse_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= flha_pkg::S_IDLE;
            euse_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            euse_reg <= euse_next;
        end
        est_reg <= est_next;
    end

    `FLHA_ASSERT_IMP(a_no_overlap, aclk, aresetn, in_ready, !out_valid,
        "input taken while a result is pending")
    `FLHA_ASSERT_NEXT(a_accept_starts, aclk, aresetn, in_valid && in_ready,
        state_reg == flha_pkg::S_DISPATCH, "accepted transaction did not start")
    `FLHA_ASSERT_NEXT(a_result_ends, aclk, aresetn, out_valid && out_ready,
        state_reg == flha_pkg::S_IDLE, "result handshake did not return to idle")
endmodule
`default_nettype wire

>>> rtl/free_list_heap_allocator_top.sv
// Top level of the free-list heap allocator.
// Channel  Handshake          Payload
// s_       s_valid/s_ready    flha_pkg::in_item_t s_data
// m_       m_valid/m_ready    flha_pkg::out_item_t m_data
// cfg      cfg_we             cfg_data (fit mode)
// One transaction at a time: each table entry visited takes a read step and a check or write step.
// An allocate scans the free table, then shifts it on a removal.
// A free scans the used table and the free table, then shifts.
// The table memories have one read and one write port, which sets the step count.
// Reset is synchronous; the tables need no clearing pass. A stalled m_ready holds the result.
`default_nettype none
module free_list_heap_allocator_top (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire flha_pkg::in_item_t s_data,
    output logic m_valid,
    input  wire logic m_ready,
    output flha_pkg::out_item_t m_data,
    input  wire logic cfg_we,
    input  wire logic cfg_data
);
    logic fit_mode_reg;
    flha_pkg::in_item_t item_reg;
    flha_pkg::cmd_t cmd;
    flha_pkg::status_flags_t flags;
    flha_pkg::out_item_t dp_result;
    logic [1:0] early_status;
    logic early_use;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            fit_mode_reg <= cfg_data;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    flha_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .flags(flags), .cmd(cmd),
        .early_status(early_status), .early_use(early_use)
    );

    flha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .fit_mode(fit_mode_reg), .item(item_reg),
        .cmd(cmd), .flags(flags), .result(dp_result)
    );

    always_comb begin
        m_data = dp_result;
        if (early_use) begin
            m_data.status = early_status;
        end
    end
endmodule
`default_nettype wire
